@@ hdl/u8u16_pkg.sv @@
// u8u16_pkg: shared types and constants for the utf-8 to utf-16 decoder
// no dependencies; used by the channel interfaces and the top level

package u8u16_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned POINT_W = 21;
    localparam int unsigned PEND_W  = 2;

    // result buffer between decode and the output channel
    localparam int unsigned BUF_DEPTH = 4;
    localparam int unsigned PTR_W     = $clog2(BUF_DEPTH);
    localparam int unsigned CNT_W     = $clog2(BUF_DEPTH + 1);

    localparam logic [UNIT_W-1:0]  REPLACEMENT = 16'hFFFD;
    localparam logic [UNIT_W-1:0]  HIGH_BASE   = 16'hD800;
    localparam logic [UNIT_W-1:0]  LOW_BASE    = 16'hDC00;
    localparam logic [POINT_W-1:0] PLANE1_BASE = 21'h10000;

    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              last_of_run;
    } unit_t;

endpackage

@@ hdl/u8u16_chan_if.sv @@
// u8u16 channel interfaces: valid/ready handshake with byte and unit payloads
// depends on u8u16_pkg

interface u8u16_byte_if;
    logic                             valid;
    logic                             ready;
    logic [u8u16_pkg::BYTE_W-1:0]     in_byte;
    logic                             end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8u16_unit_if;
    logic                             valid;
    logic                             ready;
    logic [u8u16_pkg::UNIT_W-1:0]     code_unit;
    logic                             last_of_run;

    modport source (output valid, output code_unit, output last_of_run, input ready);
    modport sink   (input valid, input code_unit, input last_of_run, output ready);
endinterface

@@ hdl/utf8_to_utf16_decoder.sv @@
// utf8_to_utf16_decoder: lenient streaming utf-8 to utf-16 transcoder, top level
// depends on u8u16_pkg and the channel interfaces in u8u16_chan_if.sv
//
//  channel    dir  payload                          notes
//  byte_chan  in   in_byte[7:0], end_of_string      one utf-8 byte per transaction
//  unit_chan  out  code_unit[15:0], last_of_run     zero, one or two units per byte
//
// one byte is decoded in the cycle it is accepted; its units land in a
// four-entry result buffer and leave one per cycle from the next cycle on.
// byte_chan.ready depends only on the buffer fill (two or fewer units held), so
// a byte can be taken every cycle while the consumer keeps up or stalls briefly.
// reset is asynchronous, active low; it clears the decode state and the buffer.
// a stall on unit_chan holds the head unit; input stalls once three units wait.

module utf8_to_utf16_decoder
(
    input  logic               clk,
    input  logic               rst_n,
    u8u16_byte_if.sink         byte_chan,
    u8u16_unit_if.source       unit_chan
);

    // decode state
    logic [u8u16_pkg::POINT_W-1:0] partial_reg, partial_next;
    logic [u8u16_pkg::PEND_W-1:0]  pending_reg, pending_next;

    // result buffer
    u8u16_pkg::unit_t              buf_reg [u8u16_pkg::BUF_DEPTH];
    logic [u8u16_pkg::PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [u8u16_pkg::PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [u8u16_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    logic                          in_fire;
    logic                          out_fire;

    // decode results for the byte on the input channel
    logic [u8u16_pkg::BYTE_W-1:0]  c;
    logic [u8u16_pkg::POINT_W-1:0] acc;
    logic [u8u16_pkg::PEND_W-1:0]  pend_dec;
    logic [u8u16_pkg::POINT_W-1:0] point;
    logic                          emit;
    logic [u8u16_pkg::POINT_W-1:0] offset;
    logic                          is_pair;
    u8u16_pkg::unit_t              unit0;
    u8u16_pkg::unit_t              unit1;
    logic [1:0]                    n_units;

    assign in_fire  = byte_chan.valid && byte_chan.ready;
    assign out_fire = unit_chan.valid && unit_chan.ready;

    // room for a surrogate pair whatever the consumer does this cycle
    assign byte_chan.ready = (cnt_reg <= u8u16_pkg::CNT_W'(u8u16_pkg::BUF_DEPTH - 2));

    assign c   = byte_chan.in_byte;
    // shift in six payload bits; continuation marker is not checked
    assign acc = {partial_reg[u8u16_pkg::POINT_W-7:0], c[5:0]};
    assign pend_dec = pending_reg - u8u16_pkg::PEND_ONE;

    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        point        = '0;
        emit         = 1'b0;

        if (pending_reg == u8u16_pkg::PEND_NONE)
        begin
            if (c < 8'h80)
            begin
                point = u8u16_pkg::POINT_W'(c);
                emit  = 1'b1;
            end
            else if (c inside {[8'hC0:8'hDF]})
            begin
                partial_next = u8u16_pkg::POINT_W'(c[4:0]);
                pending_next = u8u16_pkg::PEND_ONE;
            end
            else if (c inside {[8'hE0:8'hEF]})
            begin
                partial_next = u8u16_pkg::POINT_W'(c[3:0]);
                pending_next = u8u16_pkg::PEND_TWO;
            end
            else if (c inside {[8'hF0:8'hF7]})
            begin
                partial_next = u8u16_pkg::POINT_W'(c[2:0]);
                pending_next = u8u16_pkg::PEND_THREE;
            end
            else
            begin
                // stray continuation or invalid lead byte
                point = u8u16_pkg::POINT_W'(u8u16_pkg::REPLACEMENT);
                emit  = 1'b1;
            end
        end
        else
        begin
            partial_next = acc;
            pending_next = pend_dec;
            if (pend_dec == u8u16_pkg::PEND_NONE)
            begin
                point        = acc;
                emit         = 1'b1;
                partial_next = '0;
            end
        end

        // end of string: a cut-short sequence becomes one replacement unit
        if (byte_chan.end_of_string)
        begin
            if (pending_next != u8u16_pkg::PEND_NONE)
            begin
                point = u8u16_pkg::POINT_W'(u8u16_pkg::REPLACEMENT);
                emit  = 1'b1;
            end
            partial_next = '0;
            pending_next = u8u16_pkg::PEND_NONE;
        end
    end

    // split into one unit or a surrogate pair
    assign is_pair = (point >= u8u16_pkg::PLANE1_BASE);
    assign offset  = point - u8u16_pkg::PLANE1_BASE;

    always_comb
    begin
        if (is_pair)
        begin
            unit0.code_unit   = u8u16_pkg::HIGH_BASE + u8u16_pkg::UNIT_W'(offset[20:10]);
            unit0.last_of_run = 1'b0;
            unit1.code_unit   = u8u16_pkg::LOW_BASE | u8u16_pkg::UNIT_W'(offset[9:0]);
            unit1.last_of_run = 1'b1;
        end
        else
        begin
            unit0.code_unit   = point[u8u16_pkg::UNIT_W-1:0];
            unit0.last_of_run = 1'b1;
            unit1             = unit0;
        end
    end

    assign n_units = !emit ? 2'd0 : (is_pair ? 2'd2 : 2'd1);

    // buffer pointers and fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (in_fire)
        begin
            wr_ptr_next = wr_ptr_reg + u8u16_pkg::PTR_W'(n_units);
        end
        if (out_fire)
        begin
            rd_ptr_next = rd_ptr_reg + u8u16_pkg::PTR_W'(1);
        end
        cnt_next = cnt_reg
                 + (in_fire ? u8u16_pkg::CNT_W'(n_units) : '0)
                 - (out_fire ? u8u16_pkg::CNT_W'(1) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= u8u16_pkg::PEND_NONE;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                partial_reg <= partial_next;
                pending_reg <= pending_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // buffer payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            buf_reg[wr_ptr_reg] <= unit0;
            if (is_pair)
            begin
                buf_reg[wr_ptr_reg + u8u16_pkg::PTR_W'(1)] <= unit1;
            end
        end
    end

    assign unit_chan.valid       = (cnt_reg != '0);
    assign unit_chan.code_unit   = buf_reg[rd_ptr_reg].code_unit;
    assign unit_chan.last_of_run = buf_reg[rd_ptr_reg].last_of_run;

    // buffer never overfills
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= u8u16_pkg::CNT_W'(u8u16_pkg::BUF_DEPTH))
        else $error("result buffer overflow");

    // idle decoder holds no stale bits
    a_partial_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == u8u16_pkg::PEND_NONE) |-> (partial_reg == '0))
        else $error("partial point left over with nothing pending");

    // final byte of a string always leaves the decoder idle
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && byte_chan.end_of_string) |=> (pending_reg == u8u16_pkg::PEND_NONE))
        else $error("decode state kept past end of string");

    // a high surrogate at the head always has its low half behind it
    a_pair_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_chan.valid && !unit_chan.last_of_run) |-> (cnt_reg >= u8u16_pkg::CNT_W'(2)))
        else $error("surrogate pair split in result buffer");

    // ready follows the fill level alone
    a_ready_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_chan.ready |-> (cnt_reg > u8u16_pkg::CNT_W'(u8u16_pkg::BUF_DEPTH - 2)))
        else $error("input stalled with room in buffer");

endmodule
